### rtl/core/bu2x_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bu2x_pkg
// Shared types and constants of the 2x bilinear upsampler.
// ----------------------------------------------------------------------------
package bu2x_pkg;

    localparam int REG_BITS     = 11;
    localparam int COORD_BITS   = 11;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [REG_BITS-1:0] REG_RESET = 11'd1024;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } t_cfg_index;

    // weight of the earlier source along one axis, in quarters
    typedef logic [1:0] t_weight;
    localparam t_weight W_ZERO  = 2'd0;
    localparam t_weight W_ONE   = 2'd1;
    localparam t_weight W_THREE = 2'd3;

    typedef struct packed {
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
        logic                  row_pos;
        logic                  col_pos;
        logic                  last_row;
        logic                  last_col;
    } t_src_pos;

    function automatic t_weight axis_weight(input logic pos, input logic [1:0] idx);
        t_weight w;
        w = W_ZERO;
        if (pos) begin
            unique case (idx)
                2'd0:    w = W_THREE;
                2'd1:    w = W_ONE;
                default: w = W_ZERO;
            endcase
        end
        return w;
    endfunction

endpackage
`default_nettype wire

### rtl/core/bilinear_upsample_2x.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_upsample_2x
// Streaming 2x bilinear upsampler, half-pixel centres, replicated borders.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+------------------------------
//   cfg     | in        | i_cfg_valid, o_cfg_ready | i_cfg_index, i_cfg_data
//   pixel   | in        | i_in_valid, o_in_stall   | i_pixel_in
//   result  | out       | o_out_valid, i_out_stall | row, col, pixel, run/frame end
//
// each pixel yields rows x cols results (1 to 9, 4 on average), handed out one
// per cycle by the emit stage unless the result side stalls; the next pixel
// enters while the current one is emitted. results pass the stage-1, emit and
// output registers. reset is synchronous and clears counters and the stage
// valids; the line store needs no clearing. a stall on the result side holds
// the output register and backs up through the emit stage to o_in_stall.
// ----------------------------------------------------------------------------
module bilinear_upsample_2x #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bu2x_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [bu2x_pkg::REG_BITS-1:0]       i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [PIXEL_BITS-1:0]        i_pixel_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [bu2x_pkg::COORD_BITS-1:0]     o_out_row,
    output logic [bu2x_pkg::COORD_BITS-1:0]     o_out_col,
    output logic signed [PIXEL_BITS+3:0]        o_pixel_out,
    output logic                                o_run_last,
    output logic                                o_frame_end
);

    import bu2x_pkg::*;

    localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_BITS = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int OUT_BITS = PIXEL_BITS + 4;

    typedef logic signed [PIXEL_BITS-1:0] t_pix;
    typedef logic signed [OUT_BITS-1:0]   t_acc;

    function automatic t_acc mix(input t_weight w, input t_acc a, input t_acc b);
        t_acc m;
        unique case (w)
            W_ONE:   m = a + (b <<< 1) + b;
            W_THREE: m = (a <<< 1) + a + b;
            default: m = b <<< 2;
        endcase
        return m;
    endfunction

    logic [REG_BITS-1:0] r_frame_width;
    logic [REG_BITS-1:0] r_frame_height;
    logic [COL_BITS-1:0] r_col;
    logic [ROW_BITS-1:0] r_row;
    t_pix                r_left_pixel;
    t_pix                r_upper_left;

    logic                r_s1_valid;
    t_src_pos            r_s1_pos;
    t_pix                r_s1_cur;
    t_pix                r_s1_left;

    logic                r_e_valid;
    t_src_pos            r_e_pos;
    t_pix                r_tl;
    t_pix                r_tr;
    t_pix                r_bl;
    t_pix                r_br;
    logic [1:0]          r_row_idx;
    logic [1:0]          r_col_idx;

    logic                  r_o_valid;
    logic [COORD_BITS-1:0] r_o_row;
    logic [COORD_BITS-1:0] r_o_col;
    t_acc                  r_o_pixel;
    logic                  r_o_run_last;
    logic                  r_o_frame_end;

    logic                in_accept;
    logic                s1_move;
    logic                o_load;
    logic                e_last;
    logic                e_finish;
    logic [31:0]         col_inc;
    logic [31:0]         row_inc;
    logic                last_col;
    logic                last_row;
    logic [PIXEL_BITS-1:0] ram_rd_data;
    t_pix                above;
    t_src_pos            n_pos;
    logic [1:0]          e_row_last;
    logic [1:0]          e_col_last;
    t_weight             w_row;
    t_weight             w_col;
    t_acc                mix_left;
    t_acc                mix_right;
    t_acc                n_pixel;
    logic [COORD_BITS:0] n_row_sum;
    logic [COORD_BITS:0] n_col_sum;

    // position of the incoming pixel
    always_comb begin
        col_inc  = 32'(r_col) + 32'd1;
        row_inc  = 32'(r_row) + 32'd1;
        last_col = (col_inc >= 32'(r_frame_width)) || (col_inc >= 32'(MAX_WIDTH));
        last_row = (row_inc >= 32'(r_frame_height)) || (row_inc >= 32'(MAX_HEIGHT));
        n_pos.row      = COORD_BITS'(r_row);
        n_pos.col      = COORD_BITS'(r_col);
        n_pos.row_pos  = (r_row != '0);
        n_pos.col_pos  = (r_col != '0);
        n_pos.last_row = last_row;
        n_pos.last_col = last_col;
    end

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_load      = r_e_valid && (!r_o_valid || !i_out_stall);
    assign e_row_last  = {1'b0, r_e_pos.row_pos} + {1'b0, r_e_pos.last_row};
    assign e_col_last  = {1'b0, r_e_pos.col_pos} + {1'b0, r_e_pos.last_col};
    assign e_last      = (r_row_idx == e_row_last) && (r_col_idx == e_col_last);
    assign e_finish    = o_load && e_last;
    assign s1_move     = r_s1_valid && (!r_e_valid || e_finish);
    assign o_in_stall  = r_s1_valid && !s1_move;
    assign o_cfg_ready = 1'b1;
    assign above       = t_pix'(ram_rd_data);

    bu2x_ram #(
        .DATA_BITS (PIXEL_BITS),
        .DEPTH     (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (in_accept),
        .i_wr_addr (r_col),
        .i_wr_data (i_pixel_in),
        .i_rd_en   (in_accept),
        .i_rd_addr (r_col),
        .o_rd_data (ram_rd_data)
    );

    // weighted sum for the current output position
    always_comb begin
        w_row     = axis_weight(r_e_pos.row_pos, r_row_idx);
        w_col     = axis_weight(r_e_pos.col_pos, r_col_idx);
        mix_left  = mix(w_row, t_acc'(r_tl), t_acc'(r_bl));
        mix_right = mix(w_row, t_acc'(r_tr), t_acc'(r_br));
        n_pixel   = mix(w_col, mix_left, mix_right);
        n_row_sum = {r_e_pos.row, 1'b0} + (COORD_BITS+1)'(r_row_idx)
                  - (COORD_BITS+1)'(r_e_pos.row_pos);
        n_col_sum = {r_e_pos.col, 1'b0} + (COORD_BITS+1)'(r_col_idx)
                  - (COORD_BITS+1)'(r_e_pos.col_pos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= REG_RESET;
            r_frame_height <= REG_RESET;
            r_col          <= '0;
            r_row          <= '0;
            r_left_pixel   <= '0;
            r_upper_left   <= '0;
            r_s1_valid     <= 1'b0;
            r_e_valid      <= 1'b0;
            r_row_idx      <= '0;
            r_col_idx      <= '0;
            r_o_valid      <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_FRAME_WIDTH) begin
                    r_frame_width <= i_cfg_data;
                end
                if (i_cfg_index == CFG_FRAME_HEIGHT) begin
                    r_frame_height <= i_cfg_data;
                end
            end

            if (in_accept) begin
                r_left_pixel <= i_pixel_in;
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : row_inc[ROW_BITS-1:0];
                end else begin
                    r_col <= col_inc[COL_BITS-1:0];
                end
            end

            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_move) begin
                r_upper_left <= above;
                r_e_valid    <= 1'b1;
                r_row_idx    <= '0;
                r_col_idx    <= '0;
            end else if (o_load) begin
                if (e_last) begin
                    r_e_valid <= 1'b0;
                end
                if (r_col_idx == e_col_last) begin
                    r_col_idx <= '0;
                    r_row_idx <= r_row_idx + 2'd1;
                end else begin
                    r_col_idx <= r_col_idx + 2'd1;
                end
            end

            if (o_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_pos  <= n_pos;
            r_s1_cur  <= i_pixel_in;
            r_s1_left <= r_left_pixel;
        end
        // border replication on the top row and left column
        if (s1_move) begin
            r_e_pos <= r_s1_pos;
            r_br    <= r_s1_cur;
            r_bl    <= r_s1_pos.col_pos ? r_s1_left : r_s1_cur;
            r_tr    <= r_s1_pos.row_pos ? above : r_s1_cur;
            if (r_s1_pos.row_pos) begin
                r_tl <= r_s1_pos.col_pos ? r_upper_left : above;
            end else begin
                r_tl <= r_s1_pos.col_pos ? r_s1_left : r_s1_cur;
            end
        end
        if (o_load) begin
            r_o_row       <= n_row_sum[COORD_BITS-1:0];
            r_o_col       <= n_col_sum[COORD_BITS-1:0];
            r_o_pixel     <= n_pixel;
            r_o_run_last  <= e_last;
            r_o_frame_end <= e_last && r_e_pos.last_row && r_e_pos.last_col;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_row   = r_o_row;
    assign o_out_col   = r_o_col;
    assign o_pixel_out = r_o_pixel;
    assign o_run_last  = r_o_run_last;
    assign o_frame_end = r_o_frame_end;

    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid)
        else $error("input stalled with no pixel held");

    a_frame_end_on_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |-> o_run_last)
        else $error("frame end without run last");

    a_emit_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_valid |-> ((r_row_idx <= e_row_last) && (r_col_idx <= e_col_last)))
        else $error("emit index beyond output block");

    a_emit_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (e_finish && !s1_move) |=> !r_e_valid)
        else $error("emit stage kept a finished pixel");

endmodule
`default_nettype wire

### rtl/core/bu2x_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bu2x_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module bu2x_ram #(
    parameter int DATA_BITS = 16,
    parameter int DEPTH     = 1024,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [DATA_BITS-1:0] i_wr_data,
    input  logic                 i_rd_en,
    input  logic [ADDR_BITS-1:0] i_rd_addr,
    output logic [DATA_BITS-1:0] o_rd_data
);

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [DATA_BITS-1:0] r_rd_data;

    // read-first on a shared address
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire
